### hw/rtl/stable_key_sorter_assert.svh
// assertion macros for the stable key sorter
`ifndef STABLE_KEY_SORTER_ASSERT_SVH
`define STABLE_KEY_SORTER_ASSERT_SVH

// check held outside reset
`define SKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check held at every edge, reset included
`define SKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sks_pkg.sv
// shared constants for the stable key sorter
`default_nettype none
package sks_pkg;
  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int IO_KEY_BITS = 32;
  localparam int MODE_BITS = 2;
  localparam int ADDR_BITS = 3;
  // compare mode bit positions
  localparam int MODE_DESC_BIT = 0;
  localparam int MODE_SIGNED_BIT = 1;
  // register address of compare_mode
  localparam logic [ADDR_BITS-1:0] ADDR_COMPARE_MODE = 3'd0;
endpackage
`default_nettype wire

### hw/rtl/stable_key_sorter.sv
// stable key sorter top level
// Usage: keys arrive on the input channel (in_valid/in_ready, key, last_key),
// one per transfer. A transfer with last_key set ends the set and starts a
// stable insertion sort over the stored keys in one memory with one shared
// comparator. in_ready is low from then until the last sorted key leaves.
// Loading accepts one key per cycle while in_valid is high. The sort reads
// each key through the registered memory read, holds it, compares it with
// the stored keys below it, shifting each later key up one place, and writes
// it into place. Results then leave on the output channel (out_valid,
// out_ready, sorted_key, last_out, overflowed) one key at a time, the next
// read only after the last is taken; last_out marks the final key. Keys past
// MAX_KEYS are dropped and overflowed is set on every result of that set. A
// stalled receiver holds the output register and the sequencer waits.
// compare_mode is on the APB port at address 0, read live by the comparator.
// Synchronous reset empties the store, clears the drop flag, sets
// compare_mode to unsigned ascending and returns to loading.
`default_nettype none
module stable_key_sorter #(
  parameter int MAX_KEYS = sks_pkg::MAX_KEYS_DEF,
  parameter int KEY_BITS = sks_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sks_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sks_pkg::IO_KEY_BITS-1:0]   key,
  input  wire logic                              last_key,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sks_pkg::IO_KEY_BITS-1:0]        sorted_key,
  output logic                                   last_out,
  output logic                                   overflowed
);
  import sks_pkg::*;
  `include "stable_key_sorter_assert.svh"

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_RDV, S_GETV, S_CMP, S_PUT, S_ERD, S_ELD, S_EHOLD
  } state_t;

  state_t state;
  logic [MODE_BITS-1:0] compare_mode;
  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] e;
  logic dropped;
  logic [KEY_BITS-1:0] v;

  logic [KEY_BITS-1:0] mem [MAX_KEYS];
  logic [KEY_BITS-1:0] rd_data;
  logic [IW-1:0] ra;
  logic [IW-1:0] wa;
  logic [KEY_BITS-1:0] wd;
  logic we;
  logic after;
  logic in_xfer;
  logic has_room;
  logic [CW-1:0] n_fin;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{(32-MODE_BITS){1'b0}}, compare_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_COMPARE_MODE[2])) begin
      compare_mode <= pwdata[MODE_BITS-1:0];
    end
  end

  assign in_ready = (state == S_LOAD);
  assign in_xfer = in_valid && in_ready;
  assign has_room = (count < CW'(MAX_KEYS));
  assign n_fin = has_room ? count + CW'(1) : count;

  // shared comparator: stored key against the key being inserted
  sks_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a     (rd_data),
    .b     (v),
    .mode  (compare_mode),
    .after (after)
  );

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = count[IW-1:0];
    wd = KEY_BITS'(key);
    ra = '0;
    case (state)
      S_LOAD: begin
        we = in_xfer && has_room;
      end
      S_RDV: begin
        ra = i[IW-1:0];
      end
      S_GETV: begin
        ra = IW'(i - CW'(1));
      end
      S_CMP: begin
        we = 1'b1;
        wa = j[IW-1:0];
        wd = after ? rd_data : v;
        ra = IW'(j - CW'(2));
      end
      S_PUT: begin
        we = 1'b1;
        wa = '0;
        wd = v;
      end
      S_ERD: begin
        ra = e[IW-1:0];
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  // key store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // sequencer: load, insertion sort, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      dropped <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_key) begin
              n <= n_fin;
              e <= '0;
              i <= CW'(1);
              state <= (n_fin <= CW'(1)) ? S_ERD : S_RDV;
            end
          end
        end
        S_RDV: begin
          state <= S_GETV;
        end
        S_GETV: begin
          v <= rd_data;
          j <= i;
          state <= S_CMP;
        end
        S_CMP: begin
          if (after) begin
            j <= j - CW'(1);
            if (j == CW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            i <= i + CW'(1);
            e <= '0;
            state <= (i + CW'(1) == n) ? S_ERD : S_RDV;
          end
        end
        S_PUT: begin
          i <= i + CW'(1);
          e <= '0;
          state <= (i + CW'(1) == n) ? S_ERD : S_RDV;
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          sorted_key <= IO_KEY_BITS'(rd_data);
          last_out <= (e + CW'(1) == n);
          overflowed <= dropped;
          out_valid <= 1'b1;
          state <= S_EHOLD;
        end
        S_EHOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_out) begin
              count <= '0;
              dropped <= 1'b0;
              state <= S_LOAD;
            end else begin
              e <= e + CW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // checks
  `SKS_ASSERT(a_out_only_in_hold, out_valid |-> (state == S_EHOLD), "result shown outside hold")
  `SKS_ASSERT(a_no_load_while_out, in_ready |-> !out_valid, "input taken with result pending")
  `SKS_ASSERT(a_count_bound, count <= CW'(MAX_KEYS), "key count beyond depth")
  `SKS_ASSERT_ALWAYS(a_pready_high, pready, "config port not ready")
endmodule
`default_nettype wire

### hw/rtl/sks_cmp.sv
// shared key compare unit: tells whether key a goes after key b
`default_nettype none
module sks_cmp #(
  parameter int KEY_BITS = sks_pkg::KEY_BITS_DEF
) (
  input  wire logic [KEY_BITS-1:0]          a,
  input  wire logic [KEY_BITS-1:0]          b,
  input  wire logic [sks_pkg::MODE_BITS-1:0] mode,
  output logic                              after
);
  import sks_pkg::*;

  logic [KEY_BITS-1:0] sign_flip;
  logic [KEY_BITS-1:0] a_adj;
  logic [KEY_BITS-1:0] b_adj;

  // flip sign bit so signed order becomes unsigned order
  always_comb begin
    sign_flip = '0;
    sign_flip[KEY_BITS-1] = mode[MODE_SIGNED_BIT];
    a_adj = a ^ sign_flip;
    b_adj = b ^ sign_flip;
    after = mode[MODE_DESC_BIT] ? (a_adj < b_adj) : (a_adj > b_adj);
  end
endmodule
`default_nettype wire
